[src/cdll_pkg.sv]
`default_nettype none
package cdll_pkg;

  localparam int Capacity = 32;
  localparam int SlotW    = $clog2(Capacity);
  localparam int CountW   = $clog2(Capacity + 1);
  localparam int MaxOut   = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_EXEC,
    S_DUMP,
    S_RESP
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture a new item
    logic walk;   // advance the cursor one link
    logic exec;   // apply the operation
    logic emit;   // present a dump value
    logic resp;   // present the final status result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic walk_done;  // cursor reached its target
    logic needs_walk; // operation requires a walk
    logic is_dump;    // dump operation with a non empty list
    logic dump_last;  // cursor at the last value to emit
  } stat_t;

endpackage
`default_nettype wire

[src/cdll_if.sv]
`default_nettype none
interface cdll_in_if;
  import cdll_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               op;
  logic signed [31:0]       item_value;
  logic [5:0]               position;
  modport source (output valid, op, item_value, position, input ready);
  modport sink   (input valid, op, item_value, position, output ready);
endinterface

interface cdll_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [31:0]       out_value;
  logic [5:0]               length;
  logic                     last;
  modport source (output valid, status, out_value, length, last, input ready);
  modport sink   (input valid, status, out_value, length, last, output ready);
endinterface
`default_nettype wire

[src/cdll_ctrl.sv]
`default_nettype none
module cdll_ctrl
  import cdll_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_WALK;
      S_WALK: begin
        if (stat_i.is_dump) state_d = S_DUMP;
        else if (!stat_i.needs_walk || stat_i.walk_done) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_RESP;
      S_DUMP: if (out_ready_i && stat_i.dump_last) state_d = S_IDLE;
      S_RESP: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_WALK: cmd_o.walk = stat_i.needs_walk && !stat_i.walk_done && !stat_i.is_dump;
      S_EXEC: cmd_o.exec = 1'b1;
      S_DUMP: begin
        out_valid_o = 1'b1;
        cmd_o.emit  = out_ready_i;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        cmd_o.resp  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/cdll_dpath.sv]
`default_nettype none
module cdll_dpath
  import cdll_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  input  wire logic               dump_state_i,
  input  wire logic [2:0]         op_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic [5:0]         position_i,
  output stat_t                   stat_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      out_value_o,
  output logic [5:0]              length_o,
  output logic                    last_o
);

  // Node pool
  logic [31:0]      val_mem  [Capacity];
  logic [SlotW-1:0] next_mem [Capacity];
  logic [SlotW-1:0] prev_mem [Capacity];

  logic [SlotW-1:0]  head_q, tail_q, cur_q;
  logic [CountW-1:0] count_q, step_q;
  logic [Capacity-1:0] used_q;
  op_e               op_q;
  logic [31:0]       val_q;
  logic [5:0]        pos_q;
  logic [1:0]        status_q;

  // Lowest free slot
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!used_q[i]) free_slot = SlotW'(i);
    end
  end

  logic [CountW:0] pos_ext, cnt_ext;
  assign pos_ext = (CountW + 1)'(pos_q);
  assign cnt_ext = (CountW + 1)'(count_q);

  logic empty, full, mid_ins, mid_del, ins_ok_at, del_ok_at;
  assign empty     = (count_q == '0);
  assign full      = (cnt_ext >= (CountW + 1)'(Capacity));
  assign ins_ok_at = !empty && (pos_ext <= cnt_ext) && !full;
  assign del_ok_at = !empty && (pos_ext < cnt_ext);
  assign mid_ins   = (op_q == OP_INS_AT) && ins_ok_at && (pos_q != '0)
                     && (pos_ext != cnt_ext);
  assign mid_del   = (op_q == OP_DEL_AT) && del_ok_at && (pos_q != '0)
                     && (pos_ext != cnt_ext - 1'b1);

  // Walk target: predecessor for insert, node itself for delete
  logic [CountW-1:0] walk_target;
  assign walk_target = mid_ins ? CountW'(pos_q - 6'd1) : CountW'(pos_q);

  assign stat_o.needs_walk = mid_ins || mid_del;
  assign stat_o.walk_done  = (step_q == walk_target);
  assign stat_o.is_dump    = (op_q == OP_DUMP) && !empty;
  assign stat_o.dump_last  = (step_q == count_q - 1'b1)
                             || (step_q == CountW'(MaxOut - 1));

  // Links read combinationally around the cursor, head and tail
  logic [SlotW-1:0] cur_next, cur_prev, head_next, tail_prev;
  assign cur_next  = next_mem[cur_q];
  assign cur_prev  = prev_mem[cur_q];
  assign head_next = next_mem[head_q];
  assign tail_prev = prev_mem[tail_q];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      used_q   <= '0;
      cur_q    <= '0;
      step_q   <= '0;
      status_q <= ST_OK;
      op_q     <= OP_NOP;
    end else begin
      if (cmd_i.load) begin
        op_q   <= op_e'(op_i);
        cur_q  <= head_q;
        step_q <= '0;
      end
      if (cmd_i.walk || cmd_i.emit) begin
        cur_q  <= cur_next;
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.exec) begin
        status_q <= ST_OK;
        unique case (op_q)
          OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (op_q == OP_INS_AT && empty)                status_q <= ST_EMPTY;
            else if (op_q == OP_INS_AT && pos_ext > cnt_ext) status_q <= ST_RANGE;
            else if (full)                                 status_q <= ST_FULL;
            else begin
              used_q[free_slot] <= 1'b1;
              count_q <= count_q + 1'b1;
              if (empty) begin
                head_q <= free_slot;
                tail_q <= free_slot;
              end else if (!mid_ins) begin
                if (op_q == OP_INS_FRONT || (op_q == OP_INS_AT && pos_q == '0))
                  head_q <= free_slot;
                else tail_q <= free_slot;
              end
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
            if (empty)                                 status_q <= ST_EMPTY;
            else if (op_q == OP_DEL_AT && !del_ok_at)  status_q <= ST_RANGE;
            else begin
              count_q <= count_q - 1'b1;
              if (mid_del) used_q[cur_q] <= 1'b0;
              else if (count_q == CountW'(1)) begin
                used_q[head_q] <= 1'b0;
                head_q <= '0;
                tail_q <= '0;
              end else if (op_q == OP_DEL_FRONT
                           || (op_q == OP_DEL_AT && pos_q == '0)) begin
                used_q[head_q] <= 1'b0;
                head_q <= head_next;
              end else begin
                used_q[tail_q] <= 1'b0;
                tail_q <= tail_prev;
              end
            end
          end
          OP_DUMP: status_q <= ST_EMPTY;
          default: ;
        endcase
      end
    end
  end

  // Pool writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) val_q <= item_value_i;
    if (cmd_i.load) pos_q <= position_i;
    if (cmd_i.exec) begin
      unique case (op_q)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
          if ((op_q != OP_INS_AT || ins_ok_at) && !full) begin
            val_mem[free_slot] <= val_q;
            if (empty) begin
              next_mem[free_slot] <= free_slot;
              prev_mem[free_slot] <= free_slot;
            end else if (mid_ins) begin
              next_mem[free_slot] <= cur_next;
              prev_mem[free_slot] <= cur_q;
              prev_mem[cur_next]  <= free_slot;
              next_mem[cur_q]     <= free_slot;
            end else begin
              next_mem[free_slot] <= head_q;
              prev_mem[free_slot] <= tail_q;
              prev_mem[head_q]    <= free_slot;
              next_mem[tail_q]    <= free_slot;
            end
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
          if (!empty && (op_q != OP_DEL_AT || del_ok_at) && count_q != CountW'(1)) begin
            if (mid_del) begin
              prev_mem[cur_next] <= cur_prev;
              next_mem[cur_prev] <= cur_next;
            end else if (op_q == OP_DEL_FRONT || (op_q == OP_DEL_AT && pos_q == '0)) begin
              next_mem[tail_q]    <= head_next;
              prev_mem[head_next] <= tail_q;
            end else begin
              prev_mem[head_q]    <= tail_prev;
              next_mem[tail_prev] <= head_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields
  assign status_o    = dump_state_i ? ST_OK : status_q;
  assign out_value_o = dump_state_i ? val_mem[cur_q] : '0;
  assign length_o    = 6'(count_q);
  assign last_o      = dump_state_i ? stat_o.dump_last : 1'b1;

endmodule
`default_nettype wire

[src/circular_doubly_linked_list_engine.sv]
`default_nettype none
// Circular doubly linked list engine.
// in_ch (sink): one operation per item: op, item_value, position.
// out_ch (source): results with status, out_value, length, last.
// Every operation yields one result with last set, except dump of a non-empty
// list: one result per stored value from head to tail (up to 32), last marked.
// A new node takes the lowest free slot of a 32 entry pool.
// End inserts and deletes pass from acceptance through the walk and execute
// states to the result. Indexed insert and delete in the middle of the list
// walk the links one per cycle from the head, an insert to the node before
// the position and a delete to the node itself; dump gives one value per
// cycle while the receiver is ready.
// One item is in flight at a time; the next item is accepted after the last
// result of the current one is taken.
// If the receiver stalls, the result holds and the engine waits.
// Reset (rst_ni low, asynchronous) empties the list; pool contents are left
// undefined and never read until written.
module circular_doubly_linked_list_engine
  import cdll_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cdll_in_if.sink   in_ch,
  cdll_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic  dump_state;

  cdll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Dump results come from the cursor; others from the status register
  assign dump_state = out_ch.valid && !cmd.resp;

  cdll_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .dump_state_i (dump_state),
    .op_i         (in_ch.op),
    .item_value_i (in_ch.item_value),
    .position_i   (in_ch.position),
    .stat_o       (stat),
    .status_o     (out_ch.status),
    .out_value_o  (out_ch.out_value),
    .length_o     (out_ch.length),
    .last_o       (out_ch.last)
  );

endmodule
`default_nettype wire

[tb/sv/tb_circular_doubly_linked_list_engine.sv]
`default_nettype none
module tb_circular_doubly_linked_list_engine;
  import cdll_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  cdll_in_if  in_ch ();
  cdll_out_if out_ch ();

  circular_doubly_linked_list_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [5:0]         length;
    logic               last;
  } result_t;

  // Mirror of the list: values in order from head to tail
  logic signed [31:0] list_q[$];
  result_t            expected_q[$];
  int                 err_cnt = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic void push_result(status_e st, logic signed [31:0] v, logic lst);
    result_t r;
    r.status    = st;
    r.out_value = v;
    r.length    = 6'(list_q.size());
    r.last      = lst;
    expected_q.push_back(r);
  endfunction

  // Predict results of one operation and update the list mirror
  function automatic void predict_list_op(op_e op, logic signed [31:0] v, int pos);
    int n;
    status_e st;
    n  = list_q.size();
    st = ST_OK;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (n >= Capacity) st = ST_FULL;
        else if (op == OP_INS_FRONT) list_q.push_front(v);
        else list_q.push_back(v);
      end
      OP_INS_AT: begin
        if (n == 0) st = ST_EMPTY;
        else if (pos > n) st = ST_RANGE;
        else if (n >= Capacity) st = ST_FULL;
        else list_q.insert(pos, v);
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else if (op == OP_DEL_FRONT) void'(list_q.pop_front());
        else void'(list_q.pop_back());
      end
      OP_DEL_AT: begin
        if (n == 0) st = ST_EMPTY;
        else if (pos >= n) st = ST_RANGE;
        else list_q.delete(pos);
      end
      OP_DUMP: begin
        if (n == 0) st = ST_EMPTY;
        else begin
          for (int k = 0; k < n && k < MaxOut; k++)
            push_result(ST_OK, list_q[k], (k + 1 == n || k + 1 == MaxOut));
          return;
        end
      end
      default: ;
    endcase
    push_result(st, 32'sd0, 1'b1);
  endfunction

  // Send one operation, waiting for acceptance; valid stays high for the next
  task automatic send_op(op_e op, logic signed [31:0] v, logic [5:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.item_value <= v;
    in_ch.position   <= pos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_list_op(op, v, int'(pos));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = expected_q.pop_front();
        if (out_ch.status !== e.status)
          report($sformatf("status %0d exp %0d", out_ch.status, e.status));
        if (out_ch.out_value !== e.out_value)
          report($sformatf("value %0d exp %0d", out_ch.out_value, e.out_value));
        if (out_ch.length !== e.length)
          report($sformatf("length %0d exp %0d", out_ch.length, e.length));
        if (out_ch.last !== e.last)
          report($sformatf("last %0b exp %0b", out_ch.last, e.last));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic logic signed [31:0] rand_value();
    return $signed($urandom());
  endfunction

  // Empty-list cases, extremes of value, range errors, dump
  task automatic test_directed();
    send_op(OP_DUMP, 0, 0);
    send_op(OP_DEL_FRONT, 0, 0);
    send_op(OP_DEL_BACK, 0, 0);
    send_op(OP_DEL_AT, 0, 0);
    send_op(OP_INS_AT, 32'sd5, 0);
    send_op(OP_INS_FRONT, 32'h7fffffff, 0);
    send_op(OP_INS_BACK, 32'h80000000, 0);
    send_op(OP_INS_AT, 32'hffffffff, 6'd1);
    send_op(OP_INS_AT, 32'sd0, 6'd3);
    send_op(OP_INS_AT, 32'sd1, 6'd5);
    send_op(OP_INS_AT, 32'sd2, 6'd63);
    send_op(OP_NOP, 32'sd9, 6'd9);
    send_op(OP_DUMP, 0, 0);
    send_op(OP_DEL_AT, 0, 6'd4);
    send_op(OP_DEL_AT, 0, 6'd1);
    send_op(OP_DEL_AT, 0, 6'd0);
    send_op(OP_DEL_AT, 0, 6'd1);
    send_op(OP_DUMP, 0, 0);
    send_op(OP_DEL_FRONT, 0, 0);
    send_op(OP_DEL_BACK, 0, 0);
    send_op(OP_DUMP, 0, 0);
  endtask

  // Fill the pool, hit every full path, dump 32, delete deep
  task automatic test_full_pool();
    while (list_q.size() < Capacity)
      send_op(op_e'($urandom_range(1)), rand_value(), 0);
    send_op(OP_INS_FRONT, 32'sd1, 0);
    send_op(OP_INS_BACK, 32'sd1, 0);
    send_op(OP_INS_AT, 32'sd1, 6'd32);
    send_op(OP_INS_AT, 32'sd1, 6'd33);
    send_op(OP_DUMP, 0, 0);
    send_op(OP_DEL_AT, 0, 6'd31);
    send_op(OP_DEL_AT, 0, 6'd30);
    send_op(OP_DEL_AT, 0, 6'd15);
    send_op(OP_INS_AT, 32'sd7, 6'd29);
    send_op(OP_INS_AT, 32'sd8, 6'd30);
    send_op(OP_DUMP, 0, 0);
  endtask

  // Random operations, biased toward valid positions
  task automatic test_random(int count);
    op_e op;
    int n;
    logic [5:0] pos;
    for (int i = 0; i < count; i++) begin
      n  = list_q.size();
      op = op_e'($urandom_range(7));
      if (n < 4 && $urandom_range(1)) op = OP_INS_BACK;
      if ($urandom_range(9) == 0) pos = 6'($urandom());
      else pos = 6'($urandom_range(n));
      send_op(op, rand_value(), pos);
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_NOP;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_pool();
    wait_drained();
    test_random(50);
    send_idle_pct = 71;
    test_random(50);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 71;
    test_random(50);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    test_random(50);
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0)
      $display("[circular_doubly_linked_list_engine] OK");
    else
      $display("[circular_doubly_linked_list_engine] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("[circular_doubly_linked_list_engine] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
src/cdll_pkg.sv
src/cdll_if.sv
src/cdll_ctrl.sv
src/cdll_dpath.sv
src/circular_doubly_linked_list_engine.sv
tb/sv/tb_circular_doubly_linked_list_engine.sv
